[sv/abgt_pkg.sv]
// ----------------------------------------------------------------------------
// Bar graph tally package
// Shared constants, queue entry type and state encodings for the tally block.
// ----------------------------------------------------------------------------
package abgt_pkg;

  localparam int NUM_ROWS_DEF    = 8;
  localparam int NUM_BARS_DEF    = 5;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam int NUM_MASKS    = 5;
  localparam int MASK_W       = 8;
  localparam int ADDR_W       = 4;
  localparam int ANSWER_W     = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int MAX_BARS     = 8;
  localparam int ROW_FIELD_W  = 4;
  localparam int HALF_FIELD_W = 4;

  localparam logic [NUM_MASKS-1:0][MASK_W-1:0] MASK_RESET =
    {8'd16, 8'd8, 8'd4, 8'd2, 8'd1};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASK_A = 3'd0,
    REG_MASK_B = 3'd1,
    REG_MASK_C = 3'd2,
    REG_MASK_D = 3'd3,
    REG_MASK_E = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_DOT,
    OP_RESCALE
  } op_kind_e;

  typedef struct packed {
    op_kind_e                                  kind;
    logic [ANSWER_W-1:0]                       bar;
    logic [ROW_FIELD_W-1:0]                    row;
    logic [MAX_BARS-1:0][HALF_FIELD_W-1:0]     halves;
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DOT,
    ST_BLANK,
    ST_DRAW
  } back_state_e;

endpackage

[sv/autoscale_bar_graph_tally.sv]
// ----------------------------------------------------------------------------
// Autoscaling bar graph tally
// Counts votes for up to five answers and draws them as bars on an LED
// matrix, rescaling the display when a full bar needs to grow.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_ready_o  cmd_i, answer_i
//   out      output     out_valid_o / out_ready_i row_addr_o, row_bits_o, last_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A vote below the threshold is taken and produces no write.
// The row writer issues at most one row write per cycle from its output
// register: a dot is a single write, a clear writes every row, and a rescale
// blanks every row and then redraws the halved bars.
// A two-entry command queue lets votes be taken while writes are stalled.
// Reset clears all tallies, heights and row images and sets the threshold to 1.
// ----------------------------------------------------------------------------
module autoscale_bar_graph_tally import abgt_pkg::*; #(
  parameter int NUM_ROWS    = NUM_ROWS_DEF,
  parameter int NUM_BARS    = NUM_BARS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 cmd_i,
  input  logic [ANSWER_W-1:0]  answer_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ADDR_W-1:0]    row_addr_o,
  output logic [MASK_W-1:0]    row_bits_o,
  output logic                 last_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [MASK_W-1:0]    cfg_data_i
);

  logic [NUM_MASKS-1:0][MASK_W-1:0] masks_q, masks_d;
  logic [NUM_BARS-1:0][MASK_W-1:0]  bar_masks;
  logic                             q_ready, q_push, q_valid, q_pop;
  op_t                              push_op, pop_op;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    masks_d = masks_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MASK_A: masks_d[0] = cfg_data_i;
        REG_MASK_B: masks_d[1] = cfg_data_i;
        REG_MASK_C: masks_d[2] = cfg_data_i;
        REG_MASK_D: masks_d[3] = cfg_data_i;
        REG_MASK_E: masks_d[4] = cfg_data_i;
        default:    masks_d    = masks_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      masks_q <= MASK_RESET;
    end else begin
      masks_q <= masks_d;
    end
  end

  for (genvar b = 0; b < NUM_BARS; b++) begin : g_mask
    if (b < NUM_MASKS) begin : g_reg
      assign bar_masks[b] = masks_q[b];
    end else begin : g_none
      assign bar_masks[b] = '0;
    end
  end

  abgt_front #(
    .NUM_ROWS    (NUM_ROWS),
    .NUM_BARS    (NUM_BARS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .answer_i   (answer_i),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_op_o     (push_op)
  );

  abgt_queue #(
    .WIDTH ($bits(op_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_op),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (pop_op)
  );

  abgt_back #(
    .NUM_ROWS (NUM_ROWS),
    .NUM_BARS (NUM_BARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_op_i      (pop_op),
    .bar_masks_i (bar_masks),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .row_addr_o  (row_addr_o),
    .row_bits_o  (row_bits_o),
    .last_o      (last_o)
  );

endmodule

[sv/abgt_queue.sv]
// ----------------------------------------------------------------------------
// Command queue
// Small first-in first-out buffer between the classifier and the row writer.
// ----------------------------------------------------------------------------
module abgt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = (count_q != CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_d = CNT_W'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = CNT_W'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[sv/abgt_front.sv]
// ----------------------------------------------------------------------------
// Vote classifier
// Keeps click counts, bar heights and the threshold, and turns each accepted
// clear, and each vote that reaches the threshold, into a display command for the row writer.
// ----------------------------------------------------------------------------
module abgt_front import abgt_pkg::*; #(
  parameter int NUM_ROWS    = NUM_ROWS_DEF,
  parameter int NUM_BARS    = NUM_BARS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic [ANSWER_W-1:0] answer_i,
  input  logic                q_ready_i,
  output logic                q_push_o,
  output op_t                 q_op_o
);

  localparam int HGT_W = $clog2(NUM_ROWS + 1);
  localparam logic [COUNT_WIDTH-1:0] THRESH_CAP = {1'b1, {(COUNT_WIDTH - 1){1'b0}}};

  logic [COUNT_WIDTH-1:0] counts_q  [NUM_BARS];
  logic [COUNT_WIDTH-1:0] counts_d  [NUM_BARS];
  logic [HGT_W-1:0]       heights_q [NUM_BARS];
  logic [HGT_W-1:0]       heights_d [NUM_BARS];
  logic [COUNT_WIDTH-1:0] thresh_q, thresh_d;
  logic [NUM_BARS-1:0]    hit;
  logic [COUNT_WIDTH-1:0] sel_cnt, cnt_inc;
  logic [HGT_W-1:0]       sel_hgt;
  logic                   accept, in_range;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;
  assign in_range   = ({1'b0, answer_i} < (ANSWER_W + 1)'(NUM_BARS));

  always_comb begin
    counts_d  = counts_q;
    heights_d = heights_q;
    thresh_d  = thresh_q;
    q_push_o  = 1'b0;
    q_op_o        = '0;
    q_op_o.kind   = OP_DOT;
    q_op_o.bar    = answer_i;
    sel_cnt = '0;
    sel_hgt = '0;
    for (int b = 0; b < NUM_BARS; b++) begin
      hit[b] = (answer_i == ANSWER_W'(b));
      if (hit[b]) begin
        sel_cnt = counts_q[b];
        sel_hgt = heights_q[b];
      end
    end
    cnt_inc = (sel_cnt == '1) ? sel_cnt : COUNT_WIDTH'(sel_cnt + 1'b1);

    if (accept) begin
      if (cmd_i) begin
        q_push_o    = 1'b1;
        q_op_o.kind = OP_CLEAR;
        for (int b = 0; b < NUM_BARS; b++) begin
          counts_d[b]  = '0;
          heights_d[b] = '0;
        end
        thresh_d = COUNT_WIDTH'(1);
      end else if (in_range) begin
        for (int b = 0; b < NUM_BARS; b++) begin
          if (hit[b]) begin
            counts_d[b] = cnt_inc;
          end
        end
        if (cnt_inc >= thresh_q) begin
          q_push_o = 1'b1;
          if (sel_hgt == HGT_W'(NUM_ROWS)) begin
            q_op_o.kind = OP_RESCALE;
            for (int b = 0; b < NUM_BARS; b++) begin
              heights_d[b]     = heights_q[b] >> 1;
              q_op_o.halves[b] = HALF_FIELD_W'(heights_q[b] >> 1);
              if ((heights_q[b] >> 1) != '0) begin
                counts_d[b] = '0;
              end
            end
            thresh_d = thresh_q[COUNT_WIDTH-1] ? THRESH_CAP : (thresh_q << 1);
          end else begin
            q_op_o.row = ROW_FIELD_W'(sel_hgt);
            for (int b = 0; b < NUM_BARS; b++) begin
              if (hit[b]) begin
                heights_d[b] = HGT_W'(heights_q[b] + 1'b1);
                counts_d[b]  = '0;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BARS; b++) begin
        counts_q[b]  <= '0;
        heights_q[b] <= '0;
      end
      thresh_q <= COUNT_WIDTH'(1);
    end else begin
      counts_q  <= counts_d;
      heights_q <= heights_d;
      thresh_q  <= thresh_d;
    end
  end

endmodule

[sv/abgt_back.sv]
// ----------------------------------------------------------------------------
// Row writer
// Holds the row images and carries out queued commands as row writes.
// ----------------------------------------------------------------------------
module abgt_back import abgt_pkg::*; #(
  parameter int NUM_ROWS = NUM_ROWS_DEF,
  parameter int NUM_BARS = NUM_BARS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  op_t                           q_op_i,
  input  logic [NUM_BARS-1:0][MASK_W-1:0] bar_masks_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ADDR_W-1:0]             row_addr_o,
  output logic [MASK_W-1:0]             row_bits_o,
  output logic                          last_o
);

  localparam int ROW_W  = $clog2(NUM_ROWS);
  localparam int HGT_W  = $clog2(NUM_ROWS + 1);
  localparam int HALF_W = HGT_W - 1;
  localparam int BARI_W = (NUM_BARS > 1) ? $clog2(NUM_BARS) : 1;
  localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(NUM_ROWS - 1);
  localparam logic [BARI_W-1:0] LAST_BAR = BARI_W'(NUM_BARS - 1);

  back_state_e       state_q, state_d;
  op_t               op_q, op_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ROW_W-1:0]  k_q, k_d;
  logic [BARI_W-1:0] bar_q, bar_d;
  logic              rescale_q, rescale_d;
  logic [HALF_W-1:0] halves_q [NUM_BARS];
  logic [HALF_W-1:0] halves_d [NUM_BARS];
  logic [MASK_W-1:0] image_q  [NUM_ROWS];
  logic [MASK_W-1:0] image_d  [NUM_ROWS];

  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [MASK_W-1:0] bits_q, bits_d;
  logic              last_q, last_d;

  logic              adv, emit, emit_last;
  logic [ROW_W-1:0]  emit_row;
  logic [ROW_W:0]    row_dbl;
  logic [MASK_W-1:0] emit_bits, dot_mask, draw_mask;
  logic [HALF_W-1:0] cur_half;
  logic [HGT_W-1:0]  k_ext, k_next, half_ext;
  logic              more_after;

  assign out_valid_o = out_valid_q;
  assign row_addr_o  = addr_q;
  assign row_bits_o  = bits_q;
  assign last_o      = last_q;

  assign adv      = !out_valid_q || out_ready_i;
  assign k_ext    = HGT_W'(k_q);
  assign k_next   = HGT_W'(k_ext + 1'b1);
  assign half_ext = HGT_W'(cur_half);

  always_comb begin
    dot_mask   = '0;
    draw_mask  = '0;
    cur_half   = '0;
    more_after = 1'b0;
    for (int b = 0; b < NUM_BARS; b++) begin
      if (op_q.bar == ANSWER_W'(b)) begin
        dot_mask = bar_masks_i[b];
      end
      if (bar_q == BARI_W'(b)) begin
        draw_mask = bar_masks_i[b];
        cur_half  = halves_q[b];
      end
      if ((BARI_W'(b) > bar_q) && (halves_q[b] != '0)) begin
        more_after = 1'b1;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    row_d     = row_q;
    k_d       = k_q;
    bar_d     = bar_q;
    rescale_d = rescale_q;
    halves_d  = halves_q;
    image_d   = image_q;
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_row  = '0;
    emit_bits = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          op_d      = q_op_i;
          row_d     = '0;
          k_d       = '0;
          bar_d     = '0;
          rescale_d = (q_op_i.kind == OP_RESCALE);
          for (int b = 0; b < NUM_BARS; b++) begin
            halves_d[b] = HALF_W'(q_op_i.halves[b]);
          end
          state_d = (q_op_i.kind == OP_DOT) ? ST_DOT : ST_BLANK;
        end
      end
      ST_DOT: begin
        if (adv) begin
          emit      = 1'b1;
          emit_row  = op_q.row[ROW_W-1:0];
          emit_bits = image_q[emit_row] | dot_mask;
          emit_last = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_BLANK: begin
        if (adv) begin
          emit      = 1'b1;
          emit_row  = row_q;
          emit_last = (row_q == LAST_ROW) && !rescale_q;
          if (row_q == LAST_ROW) begin
            state_d = rescale_q ? ST_DRAW : ST_IDLE;
          end else begin
            row_d = ROW_W'(row_q + 1'b1);
          end
        end
      end
      ST_DRAW: begin
        if (k_ext < half_ext) begin
          if (adv) begin
            emit      = 1'b1;
            emit_row  = k_q;
            emit_bits = image_q[k_q] | draw_mask;
            if (k_next == half_ext) begin
              k_d = '0;
              if (!more_after) begin
                emit_last = 1'b1;
                state_d   = ST_IDLE;
              end else begin
                bar_d = BARI_W'(bar_q + 1'b1);
              end
            end else begin
              k_d = ROW_W'(k_q + 1'b1);
            end
          end
        end else begin
          k_d = '0;
          if (bar_q == LAST_BAR) begin
            state_d = ST_IDLE;
          end else begin
            bar_d = BARI_W'(bar_q + 1'b1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      image_d[emit_row] = emit_bits;
    end
  end

  assign row_dbl = {emit_row, 1'b0};

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    addr_d      = addr_q;
    bits_d      = bits_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      addr_d      = ADDR_W'(row_dbl);
      bits_d      = emit_bits;
      last_d      = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      row_q       <= '0;
      k_q         <= '0;
      bar_q       <= '0;
      rescale_q   <= 1'b0;
      for (int r = 0; r < NUM_ROWS; r++) begin
        image_q[r] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      row_q       <= row_d;
      k_q         <= k_d;
      bar_q       <= bar_d;
      rescale_q   <= rescale_d;
      image_q     <= image_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    halves_q <= halves_d;
    addr_q   <= addr_d;
    bits_q   <= bits_d;
    last_q   <= last_d;
  end

endmodule

[sv/abgt_checker.sv]
// ----------------------------------------------------------------------------
// Bar graph tally checker
// Port-level assertions for the tally block, attached by a bind statement.
// ----------------------------------------------------------------------------
module abgt_checker import abgt_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 cmd_i,
  input logic [ANSWER_W-1:0]  answer_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [ADDR_W-1:0]    row_addr_o,
  input logic [MASK_W-1:0]    row_bits_o,
  input logic                 last_o,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o,
  input logic [CFG_IDX_W-1:0] cfg_index_i,
  input logic [MASK_W-1:0]    cfg_data_i
);

  // A stalled row write keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(row_addr_o) && $stable(row_bits_o) && $stable(last_o))
    else $error("stalled row write changed");

  // Row addresses are always twice a row index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> row_addr_o[0] == 1'b0)
    else $error("odd row address");

  // No write is offered while reset is held.
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("write offered during reset");

  // A waiting input transaction keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable(cmd_i) && $stable(answer_i))
    else $error("waiting input transaction changed");

  // A waiting register write keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && !cfg_ready_o |=>
      cfg_valid_i && $stable(cfg_index_i) && $stable(cfg_data_i))
    else $error("waiting register write changed");

endmodule

bind autoscale_bar_graph_tally abgt_checker u_abgt_checker (.*);

[dv/autoscale_bar_graph_tally_tb.sv]
// ----------------------------------------------------------------------------
// Autoscaling bar graph tally testbench
// Feeds vote clicks and clear commands through the input channel with random
// gaps, stalls the row write channel at random, and reprograms the bar masks
// between phases. Every row write is checked against a cycle-free model of
// the tally, the bar heights, the row images and the shared threshold.
// ----------------------------------------------------------------------------
module autoscale_bar_graph_tally_tb;
  import abgt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ROWS     = NUM_ROWS_DEF;
  localparam int NUM_BARS     = NUM_BARS_DEF;
  localparam int COUNT_WIDTH  = COUNT_WIDTH_DEF;
  localparam int COUNT_MAX    = (1 << COUNT_WIDTH) - 1;
  localparam int THRESH_CAP   = 1 << (COUNT_WIDTH - 1);
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT   = 3000;
  localparam int MAX_REPORTS  = 10;

  localparam logic CMD_VOTE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [ANSWER_W-1:0] ANS_A = 3'd0;
  localparam logic [ANSWER_W-1:0] ANS_B = 3'd1;
  localparam logic [ANSWER_W-1:0] ANS_C = 3'd2;
  localparam logic [ANSWER_W-1:0] ANS_D = 3'd3;
  localparam logic [ANSWER_W-1:0] ANS_E = 3'd4;
  localparam logic [ANSWER_W-1:0] ANS_X = 3'd5;
  localparam logic [ANSWER_W-1:0] ANS_Y = 3'd6;
  localparam logic [ANSWER_W-1:0] ANS_Z = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct {
    logic                cmd;
    logic [ANSWER_W-1:0] answer;
  } vote_item_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [MASK_W-1:0] bits;
    logic              last;
  } row_write_t;

  typedef struct {
    logic [CFG_IDX_W-1:0] idx;
    logic [MASK_W-1:0]    data;
  } mask_write_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic                 cmd       = 1'b0;
  logic [ANSWER_W-1:0]  answer    = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ADDR_W-1:0]    row_addr;
  logic [MASK_W-1:0]    row_bits;
  logic                 row_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MASK_W-1:0]    cfg_data  = '0;

  autoscale_bar_graph_tally u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .cmd_i       (cmd),
    .answer_i    (answer),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .row_addr_o  (row_addr),
    .row_bits_o  (row_bits),
    .last_o      (row_last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Model state of the display and the tallies.
  logic [MASK_W-1:0]      bar_mask [NUM_MASKS];
  logic [COUNT_WIDTH-1:0] click_count [NUM_BARS];
  logic [3:0]             bar_height [NUM_BARS];
  logic [MASK_W-1:0]      row_image [NUM_ROWS];
  int                     threshold;

  vote_item_t  pending_votes[$];
  row_write_t  staged_writes[$];
  row_write_t  exp_row_writes[$];
  mask_write_t mask_plan[$];

  int mismatches = 0;
  bit no_idle = 1'b0;
  int in_gap = 0;
  int out_stall = 0;
  int idle_cycles = 0;
  int focus_bar = 0;

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic stage_write(int row, logic [MASK_W-1:0] bits);
    row_write_t w;
    w.addr = ADDR_W'((row * 2) & 15);
    w.bits = bits;
    w.last = 1'b0;
    staged_writes.push_back(w);
  endtask

  task automatic blank_rows();
    for (int r = 0; r < NUM_ROWS; r++) begin
      row_image[r] = '0;
      stage_write(r, '0);
    end
    for (int b = 0; b < NUM_BARS; b++) bar_height[b] = '0;
  endtask

  task automatic grow_bar(int b);
    int h;
    h = bar_height[b];
    if (h >= NUM_ROWS) return;
    row_image[h] = row_image[h] | ((b < NUM_MASKS) ? bar_mask[b] : '0);
    stage_write(h, row_image[h]);
    bar_height[b] = 4'(h + 1);
    click_count[b] = '0;
  endtask

  task automatic tally_item(logic c, logic [ANSWER_W-1:0] a);
    int half [NUM_BARS];
    int b;
    row_write_t w;
    staged_writes.delete();
    if (c == CMD_CLEAR) begin
      blank_rows();
      for (int i = 0; i < NUM_BARS; i++) click_count[i] = '0;
      threshold = 1;
    end else if (a < NUM_BARS) begin
      b = a;
      if (click_count[b] < COUNT_MAX) click_count[b] = click_count[b] + 1'b1;
      if (click_count[b] >= threshold) begin
        if (bar_height[b] >= NUM_ROWS) begin
          for (int i = 0; i < NUM_BARS; i++) half[i] = bar_height[i] / 2;
          blank_rows();
          for (int i = 0; i < NUM_BARS; i++)
            for (int k = 0; k < half[i]; k++) grow_bar(i);
          threshold = threshold * 2;
          if (threshold > THRESH_CAP) threshold = THRESH_CAP;
        end else begin
          grow_bar(b);
        end
      end
    end
    for (int i = 0; i < staged_writes.size(); i++) begin
      w = staged_writes[i];
      w.last = (i == staged_writes.size() - 1);
      exp_row_writes.push_back(w);
    end
  endtask

  // Input driver.
  always @(posedge clk_i or negedge rst_n) begin
    logic busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cmd      <= CMD_VOTE;
      answer   <= ANS_A;
      in_gap = 0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        tally_item(cmd, answer);
        void'(pending_votes.pop_front());
        busy = 1'b0;
        in_gap = draw_wait();
      end
      if (!busy) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_votes.size() > 0) begin
          in_valid <= 1'b1;
          cmd      <= pending_votes[0].cmd;
          answer   <= pending_votes[0].answer;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Row write monitor.
  always @(posedge clk_i or negedge rst_n) begin
    row_write_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else if (out_valid && out_ready) begin
      if (exp_row_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected row write: addr=%0d bits=%02h last=%0b",
                   row_addr, row_bits, row_last);
      end else begin
        want = exp_row_writes.pop_front();
        if (row_addr !== want.addr || row_bits !== want.bits || row_last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("row write mismatch: expected addr=%0d bits=%02h last=%0b,",
                     want.addr, want.bits, want.last,
                     " got addr=%0d bits=%02h last=%0b",
                     row_addr, row_bits, row_last);
        end
      end
      out_stall = draw_wait();
      out_ready <= (out_stall == 0);
    end else if (!out_ready) begin
      if (out_stall > 0) out_stall = out_stall - 1;
      else out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("autoscale_bar_graph_tally test failed");
        $finish;
      end
    end
  end

  task automatic program_masks();
    for (int i = 0; i < mask_plan.size(); i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= mask_plan[i].idx;
      cfg_data  <= mask_plan[i].data;
      do @(posedge clk_i); while (!cfg_ready);
      if (mask_plan[i].idx < NUM_MASKS) bar_mask[mask_plan[i].idx] = mask_plan[i].data;
    end
    cfg_valid <= 1'b0;
    mask_plan.delete();
  endtask

  task automatic set_masks(logic [MASK_W-1:0] a, logic [MASK_W-1:0] b,
                           logic [MASK_W-1:0] c, logic [MASK_W-1:0] d,
                           logic [MASK_W-1:0] e);
    logic [MASK_W-1:0] vals [NUM_MASKS];
    mask_write_t w;
    vals = '{a, b, c, d, e};
    for (int i = 0; i < NUM_MASKS; i++) begin
      w.idx  = CFG_IDX_W'(REG_MASK_A + i);
      w.data = vals[i];
      mask_plan.push_back(w);
    end
    program_masks();
  endtask

  task automatic push_vote(logic c, logic [ANSWER_W-1:0] a);
    vote_item_t v;
    v.cmd    = c;
    v.answer = a;
    pending_votes.push_back(v);
  endtask

  // Mostly runs of votes on one bar, so bars fill up and rescale, with
  // clears and out-of-range answers mixed in.
  task automatic queue_random_votes(int n);
    int counted;
    int r;
    counted = 0;
    while (counted < n) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        push_vote(CMD_CLEAR, ANSWER_W'($urandom_range(0, 7)));
        counted++;
      end else if (r < 8) begin
        push_vote(CMD_VOTE, ANSWER_W'($urandom_range(5, 7)));
      end else if (r < 72) begin
        push_vote(CMD_VOTE, ANSWER_W'(focus_bar));
        counted++;
      end else begin
        push_vote(CMD_VOTE, ANSWER_W'($urandom_range(0, NUM_BARS - 1)));
        counted++;
      end
      if ($urandom_range(0, 19) == 0) focus_bar = $urandom_range(0, NUM_BARS - 1);
    end
  endtask

  task automatic wait_drained();
    while (pending_votes.size() != 0 || in_valid || exp_row_writes.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    mask_write_t w;
    for (int i = 0; i < NUM_MASKS; i++) bar_mask[i] = MASK_RESET[i];
    for (int i = 0; i < NUM_BARS; i++) begin
      click_count[i] = '0;
      bar_height[i]  = '0;
    end
    for (int i = 0; i < NUM_ROWS; i++) row_image[i] = '0;
    threshold = 1;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_n = 1'b1;
    @(posedge clk_i);

    // Reset masks: single dot, ignored answers, a full bar that rescales,
    // and a clear whose answer field is ignored.
    push_vote(CMD_VOTE, ANS_A);
    push_vote(CMD_VOTE, ANS_Z);
    push_vote(CMD_VOTE, ANS_X);
    repeat (9) push_vote(CMD_VOTE, ANS_B);
    push_vote(CMD_VOTE, ANS_C);
    push_vote(CMD_VOTE, ANS_Y);
    push_vote(CMD_VOTE, ANS_E);
    push_vote(CMD_CLEAR, ANS_Z);
    push_vote(CMD_VOTE, ANS_D);
    wait_drained();

    w.idx  = REG_UNMAPPED;
    w.data = MASK_W'($urandom_range(0, 255));
    mask_plan.push_back(w);
    set_masks(8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    queue_random_votes(90);
    wait_drained();

    set_masks(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_random_votes(60);
    wait_drained();

    set_masks(MASK_W'($urandom_range(0, 255)), MASK_W'($urandom_range(0, 255)),
              MASK_W'($urandom_range(0, 255)), MASK_W'($urandom_range(0, 255)),
              MASK_W'($urandom_range(0, 255)));
    queue_random_votes(100);
    wait_drained();

    set_masks(MASK_W'($urandom_range(0, 255)), MASK_W'($urandom_range(0, 255)),
              MASK_W'($urandom_range(0, 255)), MASK_W'($urandom_range(0, 255)),
              MASK_W'($urandom_range(0, 255)));
    no_idle = 1'b1;
    queue_random_votes(50);
    wait_drained();
    no_idle = 1'b0;
    queue_random_votes(50);
    wait_drained();

    if (mismatches == 0 && exp_row_writes.size() == 0) begin
      $display("autoscale_bar_graph_tally test passed");
    end else begin
      $display("autoscale_bar_graph_tally test failed");
    end
    $finish;
  end

endmodule
